### src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define EVMSP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("evmsp assertion failed");

// Condition that must never be seen outside reset.
`define EVMSP_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("evmsp forbidden condition seen");

`endif

### src/evmsp_pkg.sv
// ----------------------------------------------------------------------------
// evmsp_pkg
// Types and constants of the EVM bytecode instruction splitter.
// ----------------------------------------------------------------------------
package evmsp_pkg;

	localparam int IMM_BYTES       = 32;
	localparam int NEED_BITS       = 6;
	localparam int POS_BITS        = 5;
	localparam int OFFSET_OUT_BITS = 24;

	localparam logic [7:0] OP_PUSH1  = 8'h60;
	localparam logic [7:0] OP_PUSH32 = 8'h7f;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       end_of_code;
	} byte_item_t;

	typedef struct packed {
		logic [OFFSET_OUT_BITS-1:0] instr_offset;
		logic [7:0]                 opcode;
		logic [63:0]                imm_bits_255_192;
		logic [63:0]                imm_bits_191_128;
		logic [63:0]                imm_bits_127_64;
		logic [63:0]                imm_bits_63_0;
		logic                       final_instr;
	} instr_item_t;

endpackage

### src/evmsp_byte_if.sv
// ----------------------------------------------------------------------------
// evmsp_byte_if
// Valid/ready channel carrying one bytecode byte per transfer.
// ----------------------------------------------------------------------------
interface evmsp_byte_if;
	logic                  valid;
	logic                  ready;
	evmsp_pkg::byte_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/evmsp_instr_if.sv
// ----------------------------------------------------------------------------
// evmsp_instr_if
// Valid/ready channel carrying one decoded instruction per transfer.
// ----------------------------------------------------------------------------
interface evmsp_instr_if;
	logic                   valid;
	logic                   ready;
	evmsp_pkg::instr_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/evmsp_decoder.sv
// ----------------------------------------------------------------------------
// evmsp_decoder
// Byte-level splitter state: offset counter, PUSH byte counter and the
// immediate accumulator. Produces at most one instruction per byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module evmsp_decoder #(
	parameter int OFFSET_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	evmsp_byte_if.sink             byte_in,
	input  logic                   can_take,
	output logic                   res_valid,
	output evmsp_pkg::instr_item_t res
);
	import evmsp_pkg::*;

	logic [OFFSET_BITS-1:0]        next_offset_q;
	logic [NEED_BITS-1:0]          needed_q;
	logic [IMM_BYTES-1:0][7:0]     acc_q;
	logic [7:0]                    held_op_q;
	logic [OFFSET_BITS-1:0]        held_off_q;

	logic                          fire;
	logic [7:0]                    b;
	logic                          last;
	logic [OFFSET_BITS-1:0]        bumped;
	logic                          is_push;
	logic [NEED_BITS-1:0]          push_len;
	logic                          collecting;
	logic [POS_BITS-1:0]           pos;
	logic [IMM_BYTES-1:0][7:0]     acc_ins;
	logic [IMM_BYTES-1:0][7:0]     imm_w;

	assign byte_in.ready = can_take;
	assign fire          = byte_in.valid && can_take;
	assign b             = byte_in.data.code_byte;
	assign last          = byte_in.data.end_of_code;

	always_comb begin
		bumped     = (&next_offset_q) ? next_offset_q : next_offset_q + 1'b1;
		is_push    = b inside {[OP_PUSH1:OP_PUSH32]};
		push_len   = {1'b0, b[POS_BITS-1:0]} + NEED_BITS'(1);
		collecting = needed_q != '0;
		pos        = POS_BITS'(needed_q - NEED_BITS'(1));
		// big-endian placement: the byte lands at lane (needed - 1)
		for (int j = 0; j < IMM_BYTES; j++) begin
			acc_ins[j] = acc_q[j] | ((pos == POS_BITS'(j)) ? b : 8'h00);
		end

		if (collecting) begin
			res_valid        = fire && ((pos == '0) || last);
			res.instr_offset = OFFSET_OUT_BITS'(held_off_q);
			res.opcode       = held_op_q;
			imm_w            = acc_ins;
		end else begin
			res_valid        = fire && (!is_push || last);
			res.instr_offset = OFFSET_OUT_BITS'(next_offset_q);
			res.opcode       = b;
			imm_w            = '0;
		end
		res.imm_bits_255_192 = imm_w[31:24];
		res.imm_bits_191_128 = imm_w[23:16];
		res.imm_bits_127_64  = imm_w[15:8];
		res.imm_bits_63_0    = imm_w[7:0];
		res.final_instr      = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_offset_q <= '0;
			needed_q      <= '0;
			acc_q         <= '0;
			held_op_q     <= '0;
			held_off_q    <= '0;
		end else if (fire) begin
			next_offset_q <= last ? '0 : bumped;
			if (collecting) begin
				acc_q    <= last ? '0 : acc_ins;
				needed_q <= last ? '0 : {1'b0, pos};
			end else begin
				acc_q      <= '0;
				held_op_q  <= b;
				held_off_q <= next_offset_q;
				needed_q   <= (is_push && !last) ? push_len : '0;
			end
		end
	end

	`EVMSP_ASSERT_NEVER(a_needed_range, clk, arst_n, needed_q > NEED_BITS'(IMM_BYTES))
	`EVMSP_ASSERT(a_end_clears, clk, arst_n, (fire && last) |=> (next_offset_q == '0 && needed_q == '0))
	`EVMSP_ASSERT(a_push_done, clk, arst_n, (fire && collecting && pos == '0) |-> res_valid)

endmodule

### src/evmsp_out_reg.sv
// ----------------------------------------------------------------------------
// evmsp_out_reg
// Result register between the decoder and the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module evmsp_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   res_valid,
	input  evmsp_pkg::instr_item_t res,
	output logic                   can_take,
	evmsp_instr_if.source          instr_out
);
	import evmsp_pkg::*;

	logic        valid_q;
	instr_item_t data_q;

	// register frees up in the same cycle its content is transferred
	assign can_take        = !valid_q || instr_out.ready;
	assign instr_out.valid = valid_q;
	assign instr_out.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && res_valid) begin
			data_q <= res;
		end
	end

	`EVMSP_ASSERT(a_no_drop, clk, arst_n, res_valid |-> can_take)
	`EVMSP_ASSERT(a_loaded, clk, arst_n, (res_valid && can_take) |=> valid_q)

endmodule

### src/evm_bytecode_instruction_splitter.sv
// An instruction appears on instr_out in the cycle after the transfer of
// the byte that completes it (opcode byte, last immediate byte or final byte).
// Throughput: one code byte per cycle, limited only by the single result
// register; byte_in stalls only while that register holds an untaken result.
// Reset (arst_n low) clears the offset, the pending byte count, the immediate
// accumulator and the valid flag of the result register; its data is not reset.
// ----------------------------------------------------------------------------
// evm_bytecode_instruction_splitter
// Splits EVM bytecode into instructions with offset, opcode and PUSH immediate.
// ----------------------------------------------------------------------------
module evm_bytecode_instruction_splitter #(
	parameter int OFFSET_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	evmsp_byte_if.sink    byte_in,
	evmsp_instr_if.source instr_out
);
	import evmsp_pkg::*;

	logic        can_take;
	logic        res_valid;
	instr_item_t res;

	evmsp_decoder #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_in),
		.can_take  (can_take),
		.res_valid (res_valid),
		.res       (res)
	);

	evmsp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.can_take  (can_take),
		.instr_out (instr_out)
	);

endmodule
